### sv/zhod_pkg.sv
// Shared types, widths and constants of the z-score outlier detector.
package zhod_pkg;

  // Field and state widths
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned MEAN_W     = SAMPLE_W + FRAC_W;
  localparam int unsigned SQ_W       = 2 * SAMPLE_W;
  localparam int unsigned MSQ_W      = SQ_W + FRAC_W;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned LEVEL_W    = 3;

  // Serial multiplier: A operand up to 80 bits, B operand up to 40 bits
  localparam int unsigned MUL_A_W   = 80;
  localparam int unsigned MUL_B_W   = 2 * SAMPLE_W - 8;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W + 1);
  localparam int unsigned DD_W      = 2 * MEAN_W;
  localparam int unsigned CMP_W     = MUL_A_W + CFG_W;

  // Serial divider: 64-bit dividend, count-wide divisor
  localparam int unsigned DIV_N_W   = MSQ_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W + 1);

  // APB
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] REQ_RESET  = 16'd100;
  localparam logic [CFG_W-1:0] INFO_RESET = 16'd512;
  localparam logic [CFG_W-1:0] WARN_RESET = 16'd640;
  localparam logic [CFG_W-1:0] CRIT_RESET = 16'd768;

  typedef logic [MUL_A_W-1:0]    mul_a_t;
  typedef logic [MUL_B_W-1:0]    mul_b_t;
  typedef logic [MUL_P_W-1:0]    mul_p_t;
  typedef logic [MUL_CNT_W-1:0]  mul_cnt_t;
  typedef logic [DIV_N_W-1:0]    div_n_t;
  typedef logic [DIV_CNT_W-1:0]  div_cnt_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [MEAN_W-1:0]     mean_t;
  typedef logic [MSQ_W-1:0]      msq_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_UPDATE   = 3'd0,
    LVL_NOMINAL  = 3'd1,
    LVL_INFO     = 3'd2,
    LVL_WARNING  = 3'd3,
    LVL_CRITICAL = 3'd4
  } level_e;

  typedef enum logic [1:0] {
    REG_REQUIRED = 2'd0,
    REG_INFO     = 2'd1,
    REG_WARNING  = 2'd2,
    REG_CRITICAL = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    THR_INFO     = 2'd0,
    THR_WARNING  = 2'd1,
    THR_CRITICAL = 2'd2
  } thr_e;

  // Codes are the number of multiplier bits consumed
  typedef enum logic [MUL_CNT_W-1:0] {
    MUL_LEN16 = 6'd16,
    MUL_LEN24 = 6'd24,
    MUL_LEN40 = 6'd40
  } mul_len_e;

  // Codes are the number of quotient bits produced
  typedef enum logic [DIV_CNT_W-1:0] {
    DIV_LEN40 = 7'd40,
    DIV_LEN64 = 7'd64
  } div_len_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]   sample_time;
  } in_beat_t;

  typedef struct packed {
    level_e            level;
    logic [TIME_W-1:0] result_time;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_W-1:0] required_samples;
    logic [CFG_W-1:0] info_threshold;
    logic [CFG_W-1:0] warning_threshold;
    logic [CFG_W-1:0] critical_threshold;
  } cfg_t;

  typedef struct packed {
    logic     start;
    mul_len_e len;
    mul_a_t   a;
    mul_b_t   b;
  } mul_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    mul_p_t prod;
  } mul_rsp_t;

  typedef struct packed {
    logic     start;
    div_len_e len;
    div_n_t   dividend;
    cnt_t     divisor;
  } div_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    div_n_t quot;
  } div_rsp_t;

  function automatic logic [CFG_W-1:0] thr_pick(cfg_t c, thr_e t);
    logic [CFG_W-1:0] v;
    unique case (t)
      THR_INFO:     v = c.info_threshold;
      THR_WARNING:  v = c.warning_threshold;
      THR_CRITICAL: v = c.critical_threshold;
      default:      v = c.critical_threshold;
    endcase
    return v;
  endfunction

endpackage

### sv/zhod_regs.sv
// APB configuration registers: learn count and the three z thresholds.
module zhod_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [zhod_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [zhod_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [zhod_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output zhod_pkg::cfg_t                      cfg_o
);

  zhod_pkg::cfg_t     cfg_q, cfg_d;
  zhod_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = zhod_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        zhod_pkg::REG_REQUIRED: cfg_d.required_samples   = pwdata[zhod_pkg::CFG_W-1:0];
        zhod_pkg::REG_INFO:     cfg_d.info_threshold     = pwdata[zhod_pkg::CFG_W-1:0];
        zhod_pkg::REG_WARNING:  cfg_d.warning_threshold  = pwdata[zhod_pkg::CFG_W-1:0];
        zhod_pkg::REG_CRITICAL: cfg_d.critical_threshold = pwdata[zhod_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      zhod_pkg::REG_REQUIRED: prdata[zhod_pkg::CFG_W-1:0] = cfg_q.required_samples;
      zhod_pkg::REG_INFO:     prdata[zhod_pkg::CFG_W-1:0] = cfg_q.info_threshold;
      zhod_pkg::REG_WARNING:  prdata[zhod_pkg::CFG_W-1:0] = cfg_q.warning_threshold;
      zhod_pkg::REG_CRITICAL: prdata[zhod_pkg::CFG_W-1:0] = cfg_q.critical_threshold;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.required_samples   <= zhod_pkg::REQ_RESET;
      cfg_q.info_threshold     <= zhod_pkg::INFO_RESET;
      cfg_q.warning_threshold  <= zhod_pkg::WARN_RESET;
      cfg_q.critical_threshold <= zhod_pkg::CRIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/zhod_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
module zhod_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  zhod_pkg::mul_req_t req_i,
  output zhod_pkg::mul_rsp_t rsp_o
);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  zhod_pkg::mul_cnt_t       cnt_q, cnt_d;
  zhod_pkg::mul_len_e       len_q, len_d;
  zhod_pkg::mul_a_t         a_q, a_d;
  zhod_pkg::mul_b_t         b_q, b_d;
  zhod_pkg::mul_p_t         p_q, p_d;
  logic [zhod_pkg::MUL_A_W:0] sum;

  always_comb begin
    sum    = {1'b0, p_q[zhod_pkg::MUL_P_W-1:zhod_pkg::MUL_B_W]}
           + {1'b0, (b_q[0] ? a_q : '0)};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    len_d  = len_q;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = zhod_pkg::mul_cnt_t'(req_i.len);
      len_d  = req_i.len;
      a_d    = req_i.a;
      b_d    = req_i.b;
      p_d    = '0;
    end else if (busy_q) begin
      // partial product enters at the top, finished bits shift down
      p_d   = {sum, p_q[zhod_pkg::MUL_B_W-1:1]};
      b_d   = b_q >> 1;
      cnt_d = cnt_q - zhod_pkg::mul_cnt_t'(1);
      if (cnt_q == zhod_pkg::mul_cnt_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // after k of 40 steps the product sits 40-k bits up
  always_comb begin
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    unique case (len_q)
      zhod_pkg::MUL_LEN16: rsp_o.prod = p_q >> (zhod_pkg::MUL_B_W - 16);
      zhod_pkg::MUL_LEN24: rsp_o.prod = p_q >> (zhod_pkg::MUL_B_W - 24);
      zhod_pkg::MUL_LEN40: rsp_o.prod = p_q;
      default:             rsp_o.prod = p_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      len_q  <= zhod_pkg::MUL_LEN40;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

endmodule

### sv/zhod_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
module zhod_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  zhod_pkg::div_req_t req_i,
  output zhod_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  zhod_pkg::div_cnt_t            cnt_q, cnt_d;
  zhod_pkg::cnt_t                r_q, r_d;
  zhod_pkg::cnt_t                d_q, d_d;
  zhod_pkg::div_n_t              q_q, q_d;
  logic [zhod_pkg::COUNT_BITS:0] rs;
  logic [zhod_pkg::COUNT_BITS:0] rdiff;
  logic                          ge;

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;

  always_comb begin
    rs     = {r_q, q_q[zhod_pkg::DIV_N_W-1]};
    rdiff  = rs - {1'b0, d_q};
    ge     = rs >= {1'b0, d_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    d_d    = d_q;
    q_d    = q_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = zhod_pkg::div_cnt_t'(req_i.len);
      r_d    = '0;
      d_d    = req_i.divisor;
      // short dividends are left-aligned so the quotient ends up right-aligned
      unique case (req_i.len)
        zhod_pkg::DIV_LEN40: q_d = {req_i.dividend[zhod_pkg::MEAN_W-1:0],
                                    {(zhod_pkg::DIV_N_W - zhod_pkg::MEAN_W){1'b0}}};
        zhod_pkg::DIV_LEN64: q_d = req_i.dividend;
        default:             q_d = req_i.dividend;
      endcase
    end else if (busy_q) begin
      r_d   = ge ? rdiff[zhod_pkg::COUNT_BITS-1:0] : rs[zhod_pkg::COUNT_BITS-1:0];
      q_d   = {q_q[zhod_pkg::DIV_N_W-2:0], ge};
      cnt_d = cnt_q - zhod_pkg::div_cnt_t'(1);
      if (cnt_q == zhod_pkg::div_cnt_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    d_q <= d_d;
    q_q <= q_d;
  end

endmodule

### sv/zscore_high_outlier_detector.sv
// Top level: running mean / sample variance tracker with z-score outlier levels.
// One sample in flight. The result register loads in ST_EMIT once the learning or
// classifying passes are done, and waits there while an earlier result sits stalled; the
// next sample is accepted at the edge after the result loads.
// Reset clears statistics, count and output valid and restores default registers.
module zscore_high_outlier_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  zhod_pkg::in_beat_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output zhod_pkg::out_beat_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [zhod_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [zhod_pkg::APB_DATA_W-1:0] pwdata,
  output logic [zhod_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_SQ    = 11'b000_0000_0010,
    ST_M2    = 11'b000_0000_0100,
    ST_QDIV  = 11'b000_0000_1000,
    ST_DD    = 11'b000_0001_0000,
    ST_TV    = 11'b000_0010_0000,
    ST_TTV   = 11'b000_0100_0000,
    ST_LRN   = 11'b000_1000_0000,
    ST_UMEAN = 11'b001_0000_0000,
    ST_UMSQ  = 11'b010_0000_0000,
    ST_EMIT  = 11'b100_0000_0000
  } state_e;

  zhod_pkg::cfg_t     cfg;
  zhod_pkg::mul_req_t mul_req;
  zhod_pkg::mul_rsp_t mul_rsp;
  zhod_pkg::div_req_t div_req;
  zhod_pkg::div_rsp_t div_rsp;

  state_e                             state_q, state_d;
  logic [zhod_pkg::SAMPLE_W-1:0]      v_q, v_d;
  logic [zhod_pkg::TIME_W-1:0]        time_q, time_d;
  logic [zhod_pkg::SQ_W-1:0]          v2_q, v2_d;
  zhod_pkg::msq_t                     m2_q, m2_d;
  zhod_pkg::msq_t                     var_q, var_d;
  logic [zhod_pkg::DD_W-1:0]          dd_q, dd_d;
  zhod_pkg::thr_e                     thr_q, thr_d;
  zhod_pkg::level_e                   level_q, level_d;
  zhod_pkg::cnt_t                     count_q, count_d;
  zhod_pkg::mean_t                    mean_q, mean_d;
  zhod_pkg::msq_t                     msq_q, msq_d;
  logic                               out_valid_q, out_valid_d;
  zhod_pkg::out_beat_t                out_data_q, out_data_d;

  zhod_pkg::mean_t                    samp_x;
  zhod_pkg::mean_t                    d_mean;
  zhod_pkg::msq_t                     samp_sq;
  zhod_pkg::msq_t                     d_msq;
  zhod_pkg::msq_t                     m2_new;
  zhod_pkg::msq_t                     var_diff;
  logic [zhod_pkg::MSQ_W:0]           msq_sum;
  zhod_pkg::cnt_t                     n_next;
  zhod_pkg::cmp_t                     rhs;
  logic                               x_ge, x_gt, reach;
  zhod_pkg::thr_e                     thr_nxt;
  logic [zhod_pkg::CFG_W-1:0]         thr_cur, thr_nxt_val;

  zhod_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  zhod_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  zhod_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    samp_x   = {v_q, {zhod_pkg::FRAC_W{1'b0}}};
    samp_sq  = {v2_q, {zhod_pkg::FRAC_W{1'b0}}};
    x_ge     = samp_x >= mean_q;
    x_gt     = samp_x > mean_q;
    d_mean   = x_ge ? (samp_x - mean_q) : (mean_q - samp_x);
    d_msq    = (samp_sq >= msq_q) ? (samp_sq - msq_q) : (msq_q - samp_sq);
    msq_sum  = {1'b0, msq_q} + {1'b0, samp_sq};
    n_next   = (&count_q) ? count_q : (count_q + zhod_pkg::cnt_t'(1));
    m2_new   = mul_rsp.prod[zhod_pkg::MSQ_W+zhod_pkg::FRAC_W-1:zhod_pkg::FRAC_W];
    var_diff = msq_q - m2_q;
    rhs      = mul_rsp.prod[zhod_pkg::CMP_W-1:0];
    reach    = zhod_pkg::cmp_t'(dd_q) >= rhs;
    thr_cur  = zhod_pkg::thr_pick(cfg, thr_q);
    unique case (thr_q)
      zhod_pkg::THR_INFO:    thr_nxt = zhod_pkg::THR_WARNING;
      zhod_pkg::THR_WARNING: thr_nxt = zhod_pkg::THR_CRITICAL;
      default:               thr_nxt = zhod_pkg::THR_CRITICAL;
    endcase
    thr_nxt_val = zhod_pkg::thr_pick(cfg, thr_nxt);
  end

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    time_d      = time_q;
    v2_d        = v2_q;
    m2_d        = m2_q;
    var_d       = var_q;
    dd_d        = dd_q;
    thr_d       = thr_q;
    level_d     = level_q;
    count_d     = count_q;
    mean_d      = mean_q;
    msq_d       = msq_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mul_req     = '0;
    mul_req.len = zhod_pkg::MUL_LEN40;
    div_req     = '0;
    div_req.len = zhod_pkg::DIV_LEN64;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          v_d           = in_data_i.sample_value;
          time_d        = in_data_i.sample_time;
          mul_req.start = 1'b1;
          mul_req.len   = zhod_pkg::MUL_LEN24;
          mul_req.a     = zhod_pkg::mul_a_t'(in_data_i.sample_value);
          mul_req.b     = zhod_pkg::mul_b_t'(in_data_i.sample_value);
          state_d       = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mul_rsp.done) begin
          v2_d = mul_rsp.prod[zhod_pkg::SQ_W-1:0];
          if (count_q < zhod_pkg::cnt_t'(cfg.required_samples)) begin
            level_d = zhod_pkg::LVL_UPDATE;
            state_d = ST_LRN;
          end else if (!x_ge) begin
            level_d = zhod_pkg::LVL_NOMINAL;
            state_d = ST_LRN;
          end else if (count_q < zhod_pkg::cnt_t'(2)) begin
            // too few samples for a variance
            level_d = x_gt ? zhod_pkg::LVL_CRITICAL : zhod_pkg::LVL_NOMINAL;
            state_d = x_gt ? ST_EMIT : ST_LRN;
          end else begin
            mul_req.start = 1'b1;
            mul_req.len   = zhod_pkg::MUL_LEN40;
            mul_req.a     = zhod_pkg::mul_a_t'(mean_q);
            mul_req.b     = zhod_pkg::mul_b_t'(mean_q);
            state_d       = ST_M2;
          end
        end
      end
      ST_M2: begin
        if (mul_rsp.done) begin
          m2_d = m2_new;
          if (m2_new > msq_q) begin
            level_d = x_gt ? zhod_pkg::LVL_CRITICAL : zhod_pkg::LVL_NOMINAL;
            state_d = x_gt ? ST_EMIT : ST_LRN;
          end else begin
            div_req.start    = 1'b1;
            div_req.len      = zhod_pkg::DIV_LEN64;
            div_req.dividend = m2_new;
            div_req.divisor  = count_q - zhod_pkg::cnt_t'(1);
            state_d          = ST_QDIV;
          end
        end
      end
      ST_QDIV: begin
        if (div_rsp.done) begin
          // var = msq - m2 * n/(n-1), must stay positive
          if (div_rsp.quot >= var_diff) begin
            level_d = x_gt ? zhod_pkg::LVL_CRITICAL : zhod_pkg::LVL_NOMINAL;
            state_d = x_gt ? ST_EMIT : ST_LRN;
          end else begin
            var_d         = var_diff - div_rsp.quot;
            thr_d         = zhod_pkg::THR_INFO;
            mul_req.start = 1'b1;
            mul_req.len   = zhod_pkg::MUL_LEN40;
            mul_req.a     = zhod_pkg::mul_a_t'(d_mean);
            mul_req.b     = zhod_pkg::mul_b_t'(d_mean);
            state_d       = ST_DD;
          end
        end
      end
      ST_DD: begin
        if (mul_rsp.done) begin
          dd_d          = mul_rsp.prod[zhod_pkg::DD_W-1:0];
          mul_req.start = 1'b1;
          mul_req.len   = zhod_pkg::MUL_LEN16;
          mul_req.a     = zhod_pkg::mul_a_t'(var_q);
          mul_req.b     = zhod_pkg::mul_b_t'(thr_cur);
          state_d       = ST_TV;
        end
      end
      ST_TV: begin
        if (mul_rsp.done) begin
          // second pass: (var * T) * T
          mul_req.start = 1'b1;
          mul_req.len   = zhod_pkg::MUL_LEN16;
          mul_req.a     = mul_rsp.prod[zhod_pkg::MUL_A_W-1:0];
          mul_req.b     = zhod_pkg::mul_b_t'(thr_cur);
          state_d       = ST_TTV;
        end
      end
      ST_TTV: begin
        if (mul_rsp.done) begin
          if (reach) begin
            if (thr_q == zhod_pkg::THR_CRITICAL) begin
              level_d = zhod_pkg::LVL_CRITICAL;
              state_d = ST_EMIT;
            end else begin
              thr_d         = thr_nxt;
              mul_req.start = 1'b1;
              mul_req.len   = zhod_pkg::MUL_LEN16;
              mul_req.a     = zhod_pkg::mul_a_t'(var_q);
              mul_req.b     = zhod_pkg::mul_b_t'(thr_nxt_val);
              state_d       = ST_TV;
            end
          end else begin
            unique case (thr_q)
              zhod_pkg::THR_INFO: begin
                level_d = zhod_pkg::LVL_NOMINAL;
                state_d = ST_LRN;
              end
              zhod_pkg::THR_WARNING: begin
                level_d = zhod_pkg::LVL_INFO;
                state_d = ST_LRN;
              end
              default: begin
                level_d = zhod_pkg::LVL_WARNING;
                state_d = ST_EMIT;
              end
            endcase
          end
        end
      end
      ST_LRN: begin
        count_d = n_next;
        if (count_q == '0) begin
          mean_d  = samp_x;
          msq_d   = samp_sq;
          state_d = ST_EMIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.len      = zhod_pkg::DIV_LEN40;
          div_req.dividend = zhod_pkg::div_n_t'(d_mean);
          div_req.divisor  = n_next;
          state_d          = ST_UMEAN;
        end
      end
      ST_UMEAN: begin
        if (div_rsp.done) begin
          mean_d = x_ge ? (mean_q + div_rsp.quot[zhod_pkg::MEAN_W-1:0])
                        : (mean_q - div_rsp.quot[zhod_pkg::MEAN_W-1:0]);
          if (count_q == zhod_pkg::cnt_t'(2)) begin
            msq_d   = msq_sum[zhod_pkg::MSQ_W] ? '1 : msq_sum[zhod_pkg::MSQ_W-1:0];
            state_d = ST_EMIT;
          end else begin
            div_req.start    = 1'b1;
            div_req.len      = zhod_pkg::DIV_LEN64;
            div_req.dividend = d_msq;
            div_req.divisor  = count_q - zhod_pkg::cnt_t'(1);
            state_d          = ST_UMSQ;
          end
        end
      end
      ST_UMSQ: begin
        if (div_rsp.done) begin
          msq_d   = (samp_sq >= msq_q) ? (msq_q + div_rsp.quot) : (msq_q - div_rsp.quot);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_data_d.level       = level_q;
          out_data_d.result_time = (level_q == zhod_pkg::LVL_UPDATE) ? '0 : time_q;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      mean_q      <= '0;
      msq_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= zhod_pkg::THR_INFO;
      level_q     <= zhod_pkg::LVL_UPDATE;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mean_q      <= mean_d;
      msq_q       <= msq_d;
      out_valid_q <= out_valid_d;
      thr_q       <= thr_d;
      level_q     <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    time_q     <= time_d;
    v2_q       <= v2_d;
    m2_q       <= m2_d;
    var_q      <= var_d;
    dd_q       <= dd_d;
    out_data_q <= out_data_d;
  end

  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier restarted while busy");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result beat raised outside emit");

  a_update_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.level == zhod_pkg::LVL_UPDATE)
      |-> (out_data_o.result_time == '0))
    else $error("update-only beat carries a timestamp");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q >= $past(count_q)))
    else $error("sample count went backwards");

endmodule
